// ===== rtl/core/cesa_pkg.sv =====
// Shared constants, types and helpers for the chunk element scatter addresser.
package cesa_pkg;

    localparam int MAX_RANK   = 4;
    localparam int DIM_BITS   = 16;
    localparam int ORIG_W     = 2 * DIM_BITS;
    localparam int GLOB_W     = ORIG_W + 1;
    localparam int AXIS_W     = $clog2(MAX_RANK);
    localparam int RANK_W     = 3;
    localparam int ORDER_W    = 8;
    localparam int SHAPE_W    = 64;
    localparam int DATA_W     = 64;
    localparam int ACC_W      = 64;
    localparam int MUL_A_W    = ACC_W - DIM_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 8 * DIM_BITS + DATA_W;
    localparam int M_TDATA_W  = ACC_W + DATA_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK        = 3'd0,
        CFG_AXIS_ORDER  = 3'd1,
        CFG_FIRST_ROW   = 3'd2,
        CFG_PAST_ROW    = 3'd3,
        CFG_ARRAY_SHAPE = 3'd4,
        CFG_CHUNK_SHAPE = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_MAP,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [ORDER_W-1:0]  axis_order;
        logic [DIM_BITS-1:0] first_row;
        logic [DIM_BITS-1:0] past_row;
        logic [SHAPE_W-1:0]  array_shape;
        logic [SHAPE_W-1:0]  chunk_shape;
    } cfg_t;

    typedef struct packed {
        logic              capture;
        logic              latch_chunk;
        logic              map;
        logic              acc;
        logic [AXIS_W-1:0] step;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Rank zero behaves as one; larger ranks are clamped to the axes available.
    function automatic logic [RANK_W-1:0] used_rank(input logic [RANK_W-1:0] rank);
        logic [RANK_W-1:0] r;
        r = rank;
        if (r == '0) begin
            r = RANK_W'(1);
        end
        if (r > RANK_W'(MAX_RANK)) begin
            r = RANK_W'(MAX_RANK);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/chunk_element_scatter_addresser.sv =====
// Top level of the chunk element scatter addresser: configuration registers and core.
// An element is captured, its chunk latched if it opens one, mapped onto the axes,
// accumulated axis by axis and then loaded into the output register once that is
// free; no new element is taken until then. The shared multiply-accumulate folds
// one axis into the row-major index per cycle.
// Reset (aresetn low, synchronous) restores the register defaults and clears the
// chunk counters, origins, extents and the output valid flag.
module chunk_element_scatter_addresser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // chunk_pos_a0..a3, extent_a0..a3 (16 bits each), element_data (64 bits)
    input  logic [cesa_pkg::S_TDATA_W-1:0]      s_tdata,
    // first_of_chunk
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // target_index (64 bits), out_data (64 bits)
    output logic [cesa_pkg::M_TDATA_W-1:0]      m_tdata,
    // inside_res
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cesa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cesa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cesa_pkg::*;

    cfg_t              cfg_reg;
    logic [RANK_W-1:0] rank_used;
    cmd_t              cmd;
    status_t           status;

    assign cfg_ready = 1'b1;
    assign rank_used = used_rank(cfg_reg.rank);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rank        <= RANK_W'(1);
            cfg_reg.axis_order  <= ORDER_W'(228);
            cfg_reg.first_row   <= '0;
            cfg_reg.past_row    <= DIM_BITS'(1);
            cfg_reg.array_shape <= 64'h0001_0001_0001_0001;
            cfg_reg.chunk_shape <= 64'h0001_0001_0001_0001;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RANK:        cfg_reg.rank        <= cfg_data[RANK_W-1:0];
                CFG_AXIS_ORDER:  cfg_reg.axis_order  <= cfg_data[ORDER_W-1:0];
                CFG_FIRST_ROW:   cfg_reg.first_row   <= cfg_data[DIM_BITS-1:0];
                CFG_PAST_ROW:    cfg_reg.past_row    <= cfg_data[DIM_BITS-1:0];
                CFG_ARRAY_SHAPE: cfg_reg.array_shape <= cfg_data[SHAPE_W-1:0];
                CFG_CHUNK_SHAPE: cfg_reg.chunk_shape <= cfg_data[SHAPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cesa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tready  (s_tready),
        .rank_used (rank_used),
        .status    (status),
        .cmd       (cmd)
    );

    cesa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_reg),
        .rank_used (rank_used),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/core/cesa_ctrl.sv =====
// Sequencer for the chunk element scatter addresser: handshakes and step control.
module cesa_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tuser,
    output logic                                s_tready,
    input  logic [cesa_pkg::RANK_W-1:0]         rank_used,
    input  cesa_pkg::status_t                   status,
    output cesa_pkg::cmd_t                      cmd
);
    import cesa_pkg::*;

    state_t            state_reg, state_next;
    logic [AXIS_W-1:0] step_reg, step_next;
    logic              last_step;

    assign last_step = ({1'b0, step_reg} == (rank_used - RANK_W'(1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = s_tuser ? ST_CHUNK : ST_MAP;
                end
            end
            ST_CHUNK: begin
                cmd.latch_chunk = 1'b1;
                state_next      = ST_MAP;
            end
            ST_MAP: begin
                cmd.map    = 1'b1;
                step_next  = '0;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (last_step) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + AXIS_W'(1);
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/cesa_dp.sv =====
// Datapath: chunk state, axis mapping, clipping, index accumulation and output register.
module cesa_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cesa_pkg::cmd_t                      cmd,
    output cesa_pkg::status_t                   status,
    input  cesa_pkg::cfg_t                      cfg,
    input  logic [cesa_pkg::RANK_W-1:0]         rank_used,
    input  logic [cesa_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cesa_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);
    import cesa_pkg::*;

    // Captured input transaction.
    logic [DIM_BITS-1:0] pos_reg    [MAX_RANK];
    logic [DIM_BITS-1:0] ext_in_reg [MAX_RANK];
    logic [DATA_W-1:0]   data_reg;

    // Chunk state.
    logic [DIM_BITS-1:0] cnt_reg  [MAX_RANK];
    logic [ORIG_W-1:0]   org_reg  [MAX_RANK];
    logic [DIM_BITS-1:0] sext_reg [MAX_RANK];

    // Per-axis terms of the current element.
    logic [DIM_BITS-1:0] shf_reg  [MAX_RANK];
    logic [DIM_BITS-1:0] aext_reg [MAX_RANK];
    logic                inside_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_tdata_reg;
    logic                 out_tuser_reg;

    logic [AXIS_W-1:0]   order     [MAX_RANK];
    logic [ORIG_W-1:0]   org_prod  [MAX_RANK];
    logic [DIM_BITS-1:0] logical   [MAX_RANK];
    logic [GLOB_W-1:0]   global_c  [MAX_RANK];
    logic [DIM_BITS-1:0] shf_c     [MAX_RANK];
    logic [DIM_BITS-1:0] aext_c    [MAX_RANK];
    logic [DIM_BITS-1:0] cnt_next  [MAX_RANK];
    logic                inside_c;
    logic                carry;
    logic [DIM_BITS-1:0] cnt_inc;
    logic [ACC_W-1:0]    prod;
    logic [ACC_W-1:0]    acc_next;

    always_comb begin
        for (int s = 0; s < MAX_RANK; s++) begin
            order[s]    = cfg.axis_order[2*s +: 2];
            org_prod[s] = ORIG_W'(pos_reg[s]) *
                          ORIG_W'(cfg.chunk_shape[DIM_BITS*s +: DIM_BITS]);
        end
    end

    // Stored counters map back to logical axes; the higher stored position wins.
    always_comb begin
        for (int a = 0; a < MAX_RANK; a++) begin
            logical[a] = '0;
        end
        for (int s = 0; s < MAX_RANK; s++) begin
            if ((RANK_W'(s) < rank_used) && ({1'b0, order[s]} < rank_used)) begin
                logical[order[s]] = cnt_reg[s];
            end
        end
    end

    always_comb begin
        inside_c = 1'b1;
        for (int a = 0; a < MAX_RANK; a++) begin
            global_c[a] = {1'b0, org_reg[a]} + GLOB_W'(logical[a]);
            if (a == 0) begin
                shf_c[a]  = global_c[a][DIM_BITS-1:0] - cfg.first_row;
                aext_c[a] = cfg.past_row - cfg.first_row;
                if ((global_c[a] < GLOB_W'(cfg.first_row)) ||
                    (global_c[a] >= GLOB_W'(cfg.past_row))) begin
                    inside_c = 1'b0;
                end
            end else begin
                shf_c[a]  = global_c[a][DIM_BITS-1:0];
                aext_c[a] = cfg.array_shape[DIM_BITS*a +: DIM_BITS];
                if ((RANK_W'(a) < rank_used) &&
                    (global_c[a] >= GLOB_W'(aext_c[a]))) begin
                    inside_c = 1'b0;
                end
            end
        end
    end

    // Odometer step: the last stored axis in use counts fastest, and the
    // outermost stored axis never wraps back to zero on its extent.
    always_comb begin
        carry   = 1'b1;
        cnt_inc = '0;
        for (int s = MAX_RANK - 1; s >= 0; s--) begin
            cnt_next[s] = cnt_reg[s];
            if ((RANK_W'(s) < rank_used) && carry) begin
                cnt_inc = cnt_reg[s] + DIM_BITS'(1);
                if ((s == 0) || (cnt_inc < sext_reg[s])) begin
                    cnt_next[s] = cnt_inc;
                    carry       = 1'b0;
                end else begin
                    cnt_next[s] = '0;
                end
            end
        end
    end

    assign prod     = ACC_W'(acc_reg[MUL_A_W-1:0]) * ACC_W'(aext_reg[cmd.step]);
    assign acc_next = prod + ACC_W'(shf_reg[cmd.step]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < MAX_RANK; s++) begin
                cnt_reg[s]  <= '0;
                org_reg[s]  <= '0;
                sext_reg[s] <= '0;
            end
        end else if (cmd.latch_chunk) begin
            for (int s = 0; s < MAX_RANK; s++) begin
                cnt_reg[s] <= '0;
                if (RANK_W'(s) < rank_used) begin
                    sext_reg[s] <= ext_in_reg[order[s]];
                    org_reg[s]  <= org_prod[s];
                end
            end
        end else if (cmd.map) begin
            for (int s = 0; s < MAX_RANK; s++) begin
                cnt_reg[s] <= cnt_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int a = 0; a < MAX_RANK; a++) begin
                pos_reg[a]    <= s_tdata[DIM_BITS*a +: DIM_BITS];
                ext_in_reg[a] <= s_tdata[DIM_BITS*(MAX_RANK+a) +: DIM_BITS];
            end
            data_reg <= s_tdata[S_TDATA_W-1 -: DATA_W];
        end
        if (cmd.map) begin
            for (int a = 0; a < MAX_RANK; a++) begin
                shf_reg[a]  <= shf_c[a];
                aext_reg[a] <= aext_c[a];
            end
            inside_reg <= inside_c;
            acc_reg    <= '0;
        end else if (cmd.acc) begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load) begin
            out_tdata_reg <= {data_reg, inside_reg ? acc_reg : {ACC_W{1'b0}}};
            out_tuser_reg <= inside_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_tdata_reg;
    assign m_tuser         = out_tuser_reg;

endmodule

// ===== rtl/core/cesa_checker.sv =====
// Port-level checks for the chunk element scatter addresser, bound to the top level.
module cesa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [cesa_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic                                m_tuser
);
    import cesa_pkg::*;

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An element outside the array or window carries a zero index.
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[ACC_W-1:0] == '0)
        else $error("outside element with nonzero index");

    // Accepting an element moves the sequencer out of its idle state, so two inputs are never accepted back to back.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in consecutive cycles");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind chunk_element_scatter_addresser cesa_checker u_cesa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the chunk element scatter addresser.
module testbench;
    import cesa_pkg::*;

    localparam logic [63:0] UNIT_EXT = 64'h0001_0001_0001_0001;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        hit;
        logic [63:0] addr;
        logic [63:0] value;
    } addr_result_t;

    typedef struct packed {
        logic                 is_reg;
        cfg_idx_t             reg_idx;
        logic [63:0]          reg_val;
        logic                 opens;
        logic [S_TDATA_W-1:0] beat;
        logic                 typed;
        logic                 want_hit;
        logic [63:0]          want_addr;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = CFG_RANK;
    logic [63:0]          cfg_data = '0;

    logic rx_ready = 1'b0;
    logic rx_hold = 1'b0;
    bit   hold_go = 1'b0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;

    // Register copies and walk state used to work out the expected addresses.
    logic [2:0]  reg_rank;
    logic [7:0]  reg_order;
    logic [15:0] reg_first_row;
    logic [15:0] reg_past_row;
    logic [63:0] reg_array_shape;
    logic [63:0] reg_chunk_shape;
    logic [15:0] walk_pos [MAX_RANK];
    logic [31:0] chunk_org [MAX_RANK];
    logic [15:0] walk_extent [MAX_RANK];

    addr_result_t pending_addr [$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_writes = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    assign m_tready = rx_ready & ~rx_hold;

    chunk_element_scatter_addresser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int axes_in_use();
        int r;
        r = int'(reg_rank);
        if (r == 0) r = 1;
        if (r > MAX_RANK) r = MAX_RANK;
        return r;
    endfunction

    function automatic addr_result_t predict_address(input logic opens,
                                                     input logic [S_TDATA_W-1:0] beat);
        int r, s, a;
        logic [1:0] lax;
        logic [15:0] coord [MAX_RANK];
        logic [15:0] rows, bumped;
        logic [63:0] glob, span, shifted, acc;
        logic keep, carry;
        addr_result_t res;
        r = axes_in_use();
        for (s = 0; s < MAX_RANK; s++) coord[s] = '0;
        if (opens) begin
            for (s = 0; s < MAX_RANK; s++) walk_pos[s] = '0;
            for (s = 0; s < r; s++) walk_extent[s] = beat[64 + 16 * reg_order[2 * s +: 2] +: 16];
            for (a = 0; a < r; a++)
                chunk_org[a] = 32'(beat[16 * a +: 16]) * 32'(reg_chunk_shape[16 * a +: 16]);
        end
        // Stored positions that name an axis outside the rank take no part in the mapping.
        for (s = 0; s < r; s++) begin
            lax = reg_order[2 * s +: 2];
            if (int'(lax) < r) coord[lax] = walk_pos[s];
        end
        keep = 1'b1;
        acc = '0;
        for (a = 0; a < r; a++) begin
            glob = 64'(chunk_org[a]);
            glob = glob + 64'(coord[a]);
            if (a == 0) begin
                rows = reg_past_row - reg_first_row;
                span = 64'(rows);
                keep = keep && (glob >= 64'(reg_first_row)) && (glob < 64'(reg_past_row));
                shifted = glob - 64'(reg_first_row);
            end else begin
                span = 64'(reg_array_shape[16 * a +: 16]);
                keep = keep && (glob < span);
                shifted = glob;
            end
            acc = acc * span + shifted;
        end
        res.hit = keep;
        res.addr = keep ? acc : '0;
        res.value = beat[S_TDATA_W-1 -: 64];
        // The last stored axis runs fastest; the outermost one never wraps back to zero.
        carry = 1'b1;
        for (s = r; s > 0; s--) begin
            if (carry) begin
                bumped = walk_pos[s - 1] + 16'd1;
                walk_pos[s - 1] = bumped;
                if (bumped < walk_extent[s - 1] || s == 1) carry = 1'b0;
                else walk_pos[s - 1] = '0;
            end
        end
        return res;
    endfunction

    function automatic row_t item_row(input logic opens, input logic [63:0] pos4,
                                      input logic [63:0] ext4, input logic [63:0] value,
                                      input logic typed, input logic want_hit,
                                      input logic [63:0] want_addr);
        row_t row;
        row.is_reg = 1'b0;
        row.reg_idx = CFG_RANK;
        row.reg_val = '0;
        row.opens = opens;
        row.beat = {value, ext4, pos4};
        row.typed = typed;
        row.want_hit = want_hit;
        row.want_addr = want_addr;
        return row;
    endfunction

    function automatic row_t reg_row(input cfg_idx_t idx, input logic [63:0] val);
        row_t row;
        row = item_row(1'b0, '0, '0, '0, 1'b0, 1'b0, '0);
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("mismatch at result %0d: %s is %h, expected %h", n_checked, what, got, exp_val);
        errors++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RANK:        reg_rank = val[2:0];
            CFG_AXIS_ORDER:  reg_order = val[7:0];
            CFG_FIRST_ROW:   reg_first_row = val[15:0];
            CFG_PAST_ROW:    reg_past_row = val[15:0];
            CFG_ARRAY_SHAPE: reg_array_shape = val;
            CFG_CHUNK_SHAPE: reg_chunk_shape = val;
            default: ;
        endcase
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic opens, input logic [S_TDATA_W-1:0] beat,
                             input logic typed, input logic want_hit,
                             input logic [63:0] want_addr);
        int gap;
        addr_result_t want;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        want = predict_address(opens, beat);
        if (typed) begin
            want.hit = want_hit;
            want.addr = want_addr;
        end
        pending_addr.push_back(want);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        s_tuser <= opens;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // Registers change only once every pending address has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_addr.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        addr_result_t want;
        int stall;
        wait (aresetn);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            @(negedge aclk);
            if (stall != 0) begin
                rx_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            rx_ready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            n_checked++;
            if (m_tuser) n_hits++;
            if (pending_addr.size() == 0) begin
                flag_mismatch("unexpected result, address", m_tdata[63:0], '0);
            end else begin
                want = pending_addr.pop_front();
                if (m_tuser !== want.hit)
                    flag_mismatch("write flag", 64'(m_tuser), 64'(want.hit));
                if (m_tdata[63:0] !== want.addr) flag_mismatch("address", m_tdata[63:0], want.addr);
                if (m_tdata[127:64] !== want.value) flag_mismatch("data", m_tdata[127:64], want.value);
            end
            if (n_checked % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        wait (hold_go);
        @(negedge aclk);
        rx_hold <= 1'b1;
        repeat (400) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        row_t plan [$];
        int i, j, r, kind, run_len, lim, phase_end, n_phases;
        logic [2:0]  rank_val;
        logic [1:0]  perm [4];
        logic [1:0]  tmp;
        logic [7:0]  order_val;
        logic [15:0] first_val, past_val, nominal;
        logic [15:0] cs_field [4];
        logic [15:0] as_field [4];
        logic [63:0] chunk_val, array_val, pos_word, ext_word, value;

        reg_rank = 3'd1;
        reg_order = 8'd228;
        reg_first_row = 16'd0;
        reg_past_row = 16'd1;
        reg_array_shape = UNIT_EXT;
        reg_chunk_shape = UNIT_EXT;
        for (i = 0; i < MAX_RANK; i++) begin
            walk_pos[i] = '0;
            chunk_org[i] = '0;
            walk_extent[i] = '0;
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Default registers: rank one, rows [0,1), every extent one.
        plan.push_back(item_row(1'b0, '0, '0, '0, 1'b1, 1'b1, 64'd0));
        plan.push_back(item_row(1'b1, '0, UNIT_EXT, ALL_ONES, 1'b1, 1'b1, 64'd0));
        plan.push_back(item_row(1'b0, ALL_ONES, ALL_ONES, '0, 1'b1, 1'b0, 64'd0));
        plan.push_back(item_row(1'b1, 64'h0000_0000_0000_FFFF, ALL_ONES,
                                64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b0, 64'd0));
        plan.push_back(item_row(1'b1, 64'hFFFF_FFFF_FFFF_0000, UNIT_EXT,
                                64'h5A5A_A5A5_F0F0_0F0F, 1'b1, 1'b1, 64'd0));
        // Full rank over wide array extents: the last stored axis moves first.
        plan.push_back(reg_row(CFG_RANK, 64'd4));
        plan.push_back(reg_row(CFG_PAST_ROW, 64'd65535));
        plan.push_back(reg_row(CFG_ARRAY_SHAPE, ALL_ONES));
        plan.push_back(item_row(1'b1, '0, 64'h0002_0002_0002_0002, 64'd1, 1'b1, 1'b1, 64'd0));
        plan.push_back(item_row(1'b0, '0, '0, 64'd2, 1'b1, 1'b1, 64'd1));
        plan.push_back(item_row(1'b0, '0, '0, 64'd3, 1'b1, 1'b1, 64'd65535));
        plan.push_back(item_row(1'b0, '0, '0, 64'd4, 1'b0, 1'b0, '0));
        // Rank zero acts as rank one.
        plan.push_back(reg_row(CFG_RANK, 64'd0));
        plan.push_back(item_row(1'b1, 64'h0000_0000_0000_FFFE, UNIT_EXT, 64'd5,
                                1'b1, 1'b1, 64'd65534));
        plan.push_back(item_row(1'b0, '0, '0, 64'd6, 1'b1, 1'b0, 64'd0));
        // Rank above the axes available is cut down to four.
        plan.push_back(reg_row(CFG_RANK, 64'd7));
        plan.push_back(item_row(1'b1, 64'h0004_0003_0002_0001, UNIT_EXT, 64'd7, 1'b0, 1'b0, '0));
        // Empty window, then a one-row window at the top of the range.
        plan.push_back(reg_row(CFG_FIRST_ROW, 64'd65534));
        plan.push_back(reg_row(CFG_PAST_ROW, 64'd65534));
        plan.push_back(item_row(1'b1, 64'h0000_0000_0000_FFFE, UNIT_EXT, 64'd8, 1'b1, 1'b0, 64'd0));
        plan.push_back(reg_row(CFG_PAST_ROW, 64'd65535));
        plan.push_back(item_row(1'b1, 64'h0000_0000_0000_FFFE, UNIT_EXT, 64'd9, 1'b1, 1'b1, 64'd0));
        // A zero array extent above axis zero blocks every write.
        plan.push_back(reg_row(CFG_ARRAY_SHAPE, 64'd0));
        plan.push_back(item_row(1'b1, 64'h0000_0000_0000_FFFE, UNIT_EXT, 64'd10, 1'b1, 1'b0, 64'd0));
        // Axis orders where every stored position names the same logical axis.
        plan.push_back(reg_row(CFG_ARRAY_SHAPE, ALL_ONES));
        plan.push_back(reg_row(CFG_FIRST_ROW, 64'd0));
        plan.push_back(reg_row(CFG_AXIS_ORDER, 64'd0));
        plan.push_back(item_row(1'b1, '0, 64'h0001_0001_0001_0003, 64'd11, 1'b0, 1'b0, '0));
        plan.push_back(item_row(1'b0, '0, '0, 64'd12, 1'b0, 1'b0, '0));
        plan.push_back(item_row(1'b0, '0, '0, 64'd13, 1'b0, 1'b0, '0));
        plan.push_back(reg_row(CFG_AXIS_ORDER, 64'd255));
        plan.push_back(item_row(1'b1, 64'h0001_0000_0000_0000, 64'h0002_0001_0001_0001,
                                64'd14, 1'b0, 1'b0, '0));
        plan.push_back(item_row(1'b0, '0, '0, 64'd15, 1'b0, 1'b0, '0));
        // Largest and zero nominal chunk extents.
        plan.push_back(reg_row(CFG_CHUNK_SHAPE, ALL_ONES));
        plan.push_back(item_row(1'b1, UNIT_EXT, UNIT_EXT, 64'd16, 1'b1, 1'b0, 64'd0));
        plan.push_back(reg_row(CFG_CHUNK_SHAPE, 64'd0));
        plan.push_back(reg_row(CFG_AXIS_ORDER, 64'd228));
        plan.push_back(item_row(1'b1, ALL_ONES, UNIT_EXT, 64'd17, 1'b1, 1'b1, 64'd0));
        // Zero actual extents carry on every element.
        plan.push_back(item_row(1'b1, '0, '0, 64'd18, 1'b0, 1'b0, '0));
        plan.push_back(item_row(1'b0, '0, '0, 64'd19, 1'b0, 1'b0, '0));
        plan.push_back(item_row(1'b0, '0, '0, 64'd20, 1'b0, 1'b0, '0));

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                drain_results();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_item(plan[k].opens, plan[k].beat, plan[k].typed,
                          plan[k].want_hit, plan[k].want_addr);
            end
        end

        n_phases = 0;
        while (n_sent < 700) begin
            drain_results();
            n_phases++;
            case ($urandom_range(0, 7))
                0: rank_val = 3'd0;
                1: rank_val = 3'($urandom_range(5, 7));
                default: rank_val = 3'($urandom_range(1, 4));
            endcase
            write_reg(CFG_RANK, 64'(rank_val));
            r = axes_in_use();
            // Mostly a permutation of the axes in use; now and then arbitrary bits.
            for (i = 0; i < 4; i++) perm[i] = (i < r) ? 2'(i) : 2'($urandom_range(0, 3));
            for (i = r - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            order_val = {perm[3], perm[2], perm[1], perm[0]};
            if ($urandom_range(0, 7) == 0) order_val = 8'($urandom);
            write_reg(CFG_AXIS_ORDER, 64'(order_val));

            first_val = 16'($urandom_range(0, 6));
            past_val = first_val + 16'($urandom_range(1, 12));
            case ($urandom_range(0, 7))
                0: begin
                    first_val = 16'd0;
                    past_val = 16'hFFFF;
                end
                1: begin
                    first_val = 16'hFFFE;
                    past_val = 16'hFFFF;
                end
                2: past_val = first_val - 16'($urandom_range(0, 2));
                default: ;
            endcase
            write_reg(CFG_FIRST_ROW, 64'(first_val));
            write_reg(CFG_PAST_ROW, 64'(past_val));

            for (i = 0; i < 4; i++) begin
                cs_field[i] = 16'($urandom_range(1, 4));
                as_field[i] = 16'($urandom_range(1, 12));
            end
            chunk_val = {cs_field[3], cs_field[2], cs_field[1], cs_field[0]};
            array_val = {as_field[3], as_field[2], as_field[1], as_field[0]};
            case ($urandom_range(0, 9))
                0: chunk_val = {$urandom, $urandom};
                1: chunk_val = '0;
                2: array_val = {$urandom, $urandom};
                3: array_val = ALL_ONES;
                4: array_val[16 +: 16] = '0;
                default: ;
            endcase
            write_reg(CFG_ARRAY_SHAPE, array_val);
            write_reg(CFG_CHUNK_SHAPE, chunk_val);

            phase_end = n_sent + $urandom_range(60, 110);
            if (n_phases == 3) hold_go = 1'b1;
            while (n_sent < phase_end) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 9);
                for (i = 0; i < 4; i++) begin
                    lim = (r >= 3) ? 3 : 4;
                    nominal = reg_chunk_shape[16 * i +: 16];
                    if (nominal != 0 && int'(nominal) < lim) lim = int'(nominal);
                    pos_word[16 * i +: 16] = 16'($urandom_range(0, 3));
                    ext_word[16 * i +: 16] = 16'($urandom_range(1, lim));
                end
                run_len = 1;
                for (i = 0; i < r; i++)
                    run_len = run_len * int'(ext_word[16 * reg_order[2 * i +: 2] +: 16]);
                // Mostly whole chunks; the rest are noise, overruns and cut-short chunks.
                if (kind == 0) begin
                    pos_word = {$urandom, $urandom};
                    ext_word = {$urandom, $urandom};
                    run_len = $urandom_range(1, 6);
                end else if (kind == 1) begin
                    run_len = run_len + $urandom_range(1, 6);
                end else if (kind == 2) begin
                    run_len = $urandom_range(1, run_len);
                end
                for (i = 0; i < run_len; i++) begin
                    value = {$urandom, $urandom};
                    if (i == 0) begin
                        send_item(1'b1, {value, ext_word, pos_word}, 1'b0, 1'b0, '0);
                    end else begin
                        send_item(1'b0, {value, $urandom, $urandom, $urandom, $urandom},
                                  1'b0, 1'b0, '0);
                    end
                end
            end
        end

        tx_burst = 1'b0;
        drain_results();
        $display("Run covered %0d elements in %0d register writes over %0d random settings.",
                 n_sent, n_writes, n_phases);
        $display("%0d addresses checked, %0d of them inside the array and row window.",
                 n_checked, n_hits);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cesa_pkg.sv
rtl/core/cesa_ctrl.sv
rtl/core/cesa_dp.sv
rtl/core/chunk_element_scatter_addresser.sv
rtl/core/cesa_checker.sv
verif/testbench.sv
